@@ design/threshold_spike_extractor_unit_defines.svh @@
`ifndef THRESHOLD_SPIKE_EXTRACTOR_UNIT_DEFINES_SVH
`define THRESHOLD_SPIKE_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define TSX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tsx check failed");

// next-cycle implication
`define TSX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tsx check failed");

`endif

@@ design/tsx_pkg.sv @@
package tsx_pkg;

	localparam int MAX_SAMPLES   = 4096;
	localparam int SAMPLE_BITS   = 16;
	localparam int POS_BITS      = 12;
	localparam int WIDTH_BITS    = 13;
	localparam int GAP_BITS      = 8;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_COUNT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_IGNORE_COUNT  = 2'd2;

	localparam logic [WIDTH_BITS-1:0] RUN_MAX = WIDTH_BITS'(MAX_SAMPLES);
	localparam logic [POS_BITS-1:0]   POS_MAX = POS_BITS'(MAX_SAMPLES - 1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          frame_last;
	} in_word_t;

	typedef struct packed {
		logic [POS_BITS-1:0]           peak_index;
		logic signed [SAMPLE_BITS-1:0] peak_value;
		logic [WIDTH_BITS-1:0]         spike_width;
	} out_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] threshold;
		logic [WIDTH_BITS-1:0]         confirm_count;
		logic [GAP_BITS-1:0]           ignore_count;
	} cfg_t;

endpackage

@@ design/tsx_cfg_regs.sv @@
module tsx_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tsx_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tsx_pkg::CFG_DATA_BITS-1:0]    cfg_data,
	output tsx_pkg::cfg_t                        cfg
);

	tsx_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= '0;
			cfg_q.confirm_count <= tsx_pkg::WIDTH_BITS'(1);
			cfg_q.ignore_count  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsx_pkg::REG_THRESHOLD: begin
					cfg_q.threshold <= cfg_data[tsx_pkg::SAMPLE_BITS-1:0];
				end
				tsx_pkg::REG_CONFIRM_COUNT: begin
					cfg_q.confirm_count <= cfg_data[tsx_pkg::WIDTH_BITS-1:0];
				end
				tsx_pkg::REG_IGNORE_COUNT: begin
					cfg_q.ignore_count <= cfg_data[tsx_pkg::GAP_BITS-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/tsx_in_stage.sv @@
module tsx_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_ready,
	input  tsx_pkg::in_word_t sample_word,
	input  logic              advance,
	output logic              valid,
	output tsx_pkg::in_word_t word
);

	logic              valid_s1;
	tsx_pkg::in_word_t word_s1;

	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			word_s1 <= sample_word;
		end
	end

	assign valid = valid_s1;
	assign word  = word_s1;

endmodule

@@ design/tsx_core.sv @@
module tsx_core (
	input  logic               clk,
	input  logic               arst_n,
	input  tsx_pkg::cfg_t      cfg,
	input  logic               advance,
	input  tsx_pkg::in_word_t  word,
	output logic               hit,
	output tsx_pkg::out_word_t result,
	output logic [tsx_pkg::POS_BITS-1:0] position
);

	logic                                  in_spike_q;
	logic [tsx_pkg::WIDTH_BITS-1:0]        run_q;
	logic [tsx_pkg::GAP_BITS-1:0]          gap_q;
	logic [tsx_pkg::POS_BITS-1:0]          best_idx_q;
	logic signed [tsx_pkg::SAMPLE_BITS-1:0] best_val_q;
	logic [tsx_pkg::POS_BITS-1:0]          pos_q;

	logic                                  in_spike_d;
	logic [tsx_pkg::WIDTH_BITS-1:0]        run_d;
	logic [tsx_pkg::GAP_BITS-1:0]          gap_d;
	logic [tsx_pkg::POS_BITS-1:0]          best_idx_d;
	logic signed [tsx_pkg::SAMPLE_BITS-1:0] best_val_d;
	logic [tsx_pkg::POS_BITS-1:0]          pos_d;

	logic signed [tsx_pkg::SAMPLE_BITS-1:0] s;
	logic signed [tsx_pkg::SAMPLE_BITS-1:0] thr;
	logic                                  above;
	logic [tsx_pkg::WIDTH_BITS-1:0]        run_inc;
	logic [tsx_pkg::WIDTH_BITS:0]          need;

	always_comb begin
		s       = word.sample;
		thr     = cfg.threshold;
		above   = (s > thr) && !word.frame_last;
		run_inc = (run_q < tsx_pkg::RUN_MAX) ? run_q + 1'b1 : run_q;
		need    = {1'b0, cfg.confirm_count}
			+ {{(tsx_pkg::WIDTH_BITS + 1 - tsx_pkg::GAP_BITS){1'b0}}, cfg.ignore_count};

		in_spike_d = in_spike_q;
		run_d      = run_q;
		gap_d      = gap_q;
		best_idx_d = best_idx_q;
		best_val_d = best_val_q;
		pos_d      = pos_q;
		hit        = 1'b0;

		result.peak_index  = best_idx_q;
		result.peak_value  = best_val_q;
		result.spike_width = run_q;

		if (above) begin
			if (!in_spike_q) begin
				in_spike_d = 1'b1;
				run_d      = tsx_pkg::WIDTH_BITS'(1);
				best_idx_d = pos_q;
				best_val_d = s;
			end else begin
				if (best_val_q < s) begin
					best_idx_d = pos_q;
					best_val_d = s;
				end
				run_d = run_inc;
			end
			gap_d = '0;
		end else if (in_spike_q) begin
			if (cfg.ignore_count > gap_q) begin
				run_d = run_inc;
				gap_d = gap_q + 1'b1;
			end else begin
				hit        = {1'b0, run_q} >= need;
				in_spike_d = 1'b0;
				run_d      = '0;
				gap_d      = '0;
				best_idx_d = '0;
				best_val_d = '0;
			end
		end

		// frame end clears everything
		if (word.frame_last) begin
			in_spike_d = 1'b0;
			run_d      = '0;
			gap_d      = '0;
			best_idx_d = '0;
			best_val_d = '0;
			pos_d      = '0;
		end else if (pos_q < tsx_pkg::POS_MAX) begin
			pos_d = pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_spike_q <= 1'b0;
			run_q      <= '0;
			gap_q      <= '0;
			best_idx_q <= '0;
			best_val_q <= '0;
			pos_q      <= '0;
		end else if (advance) begin
			in_spike_q <= in_spike_d;
			run_q      <= run_d;
			gap_q      <= gap_d;
			best_idx_q <= best_idx_d;
			best_val_q <= best_val_d;
			pos_q      <= pos_d;
		end
	end

	assign position = pos_q;

endmodule

@@ design/tsx_out_stage.sv @@
module tsx_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               hit,
	input  tsx_pkg::out_word_t result,
	output logic               free,
	output logic               spike_valid,
	input  logic               spike_ready,
	output tsx_pkg::out_word_t spike_word
);

	logic               valid_q;
	tsx_pkg::out_word_t word_q;

	assign free = !valid_q || spike_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= hit;
		end else if (spike_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			word_q <= result;
		end
	end

	assign spike_valid = valid_q;
	assign spike_word  = word_q;

endmodule

@@ design/threshold_spike_extractor_unit.sv @@
// Threshold run peak detector. Takes one sample word per cycle, sustained, as long as
// the result side keeps up; a sample whose run closes yields its spike word via one input
// register and one result register. Run state updates once per sample, giving one sample
// per clock while the result side keeps up. The user must write configuration through
// cfg_we/cfg_index/cfg_data only while no sample is in flight; the block does not enforce it.
`include "threshold_spike_extractor_unit_defines.svh"

module threshold_spike_extractor_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tsx_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tsx_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic                              sample_valid,
	output logic                              sample_ready,
	input  tsx_pkg::in_word_t                 sample_word,
	output logic                              spike_valid,
	input  logic                              spike_ready,
	output tsx_pkg::out_word_t                spike_word
);

	tsx_pkg::cfg_t      cfg;
	logic               s1_valid;
	tsx_pkg::in_word_t  s1_word;
	logic               out_free;
	logic               advance;
	logic               hit;
	tsx_pkg::out_word_t result;
	logic [tsx_pkg::POS_BITS-1:0] position;

	assign advance = s1_valid && out_free;

	tsx_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tsx_in_stage u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.advance      (advance),
		.valid        (s1_valid),
		.word         (s1_word)
	);

	tsx_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.advance  (advance),
		.word     (s1_word),
		.hit      (hit),
		.result   (result),
		.position (position)
	);

	tsx_out_stage u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.hit         (hit),
		.result      (result),
		.free        (out_free),
		.spike_valid (spike_valid),
		.spike_ready (spike_ready),
		.spike_word  (spike_word)
	);

	`TSX_ASSERT_NOW(a_empty_stage_ready, clk, arst_n, !s1_valid, sample_ready)
	`TSX_ASSERT_NOW(a_new_word_from_advance, clk, arst_n, $rose(spike_valid), $past(advance))
	`TSX_ASSERT_NOW(a_width_nonzero, clk, arst_n, spike_valid, spike_word.spike_width != '0)
	`TSX_ASSERT_NEXT(a_frame_end_rewinds, clk, arst_n, advance && s1_word.frame_last, position == '0)

endmodule
